// ===== rtl/tsia_pkg.sv =====
// Shared types and constants for the time-series interpolation and averaging block.
`timescale 1ns / 1ps
package tsia_pkg;

  localparam int unsigned TW = 48;
  localparam int unsigned PW = 96;

  localparam logic [2:0] REQ_LOAD_TIME = 3'd0;
  localparam logic [2:0] REQ_LOAD_VAL  = 3'd1;
  localparam logic [2:0] REQ_SET_KIND  = 3'd2;
  localparam logic [2:0] REQ_POINT     = 3'd3;
  localparam logic [2:0] REQ_INTERVAL  = 3'd4;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_ABSENT  = 2'd1;
  localparam logic [1:0] STAT_NOCOVER = 2'd2;

  localparam logic [1:0] KIND_INTERP = 2'd0;
  localparam logic [1:0] KIND_RATE   = 2'd1;

  typedef enum logic [0:0] {
    MD_MUL,
    MD_DIV
  } md_op_e;

  typedef struct packed {
    logic          start;
    md_op_e        op;
    logic [PW-1:0] a;
    logic [TW-1:0] b;
  } md_req_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SRCH,
    ST_SCMP,
    ST_PSEL,
    ST_PHOLD,
    ST_PR1,
    ST_PR2,
    ST_PMUL,
    ST_PDIV,
    ST_IRD,
    ST_ICHK,
    ST_IMUL,
    ST_ILAST,
    ST_ILCHK,
    ST_IDIV,
    ST_IDWAIT,
    ST_RESP
  } state_e;

endpackage

// ===== rtl/tsia_mem.sv =====
// Sample time and sample value memories with registered read data.
`timescale 1ns / 1ps
module tsia_mem #(
  parameter int unsigned AW     = 10,
  parameter int unsigned VAW    = 14,
  parameter int unsigned TDEPTH = 1024
) (
  input  logic                    clk_i,
  input  logic                    t_we_i,
  input  logic [AW-1:0]           t_waddr_i,
  input  logic [tsia_pkg::TW-1:0] t_wdata_i,
  input  logic [AW-1:0]           t_raddr_i,
  output logic [tsia_pkg::TW-1:0] t_rdata_o,
  input  logic                    v_we_i,
  input  logic [VAW-1:0]          v_waddr_i,
  input  logic [tsia_pkg::TW-1:0] v_wdata_i,
  input  logic [VAW-1:0]          v_raddr_i,
  output logic [tsia_pkg::TW-1:0] v_rdata_o
);
  import tsia_pkg::*;

  logic [TW-1:0] time_mem [TDEPTH];
  logic [TW-1:0] val_mem  [2**VAW];

  always_ff @(posedge clk_i) begin
    if (t_we_i) begin
      time_mem[t_waddr_i] <= t_wdata_i;
    end
    t_rdata_o <= time_mem[t_raddr_i];
  end

  always_ff @(posedge clk_i) begin
    if (v_we_i) begin
      val_mem[v_waddr_i] <= v_wdata_i;
    end
    v_rdata_o <= val_mem[v_raddr_i];
  end

endmodule

// ===== rtl/tsia_muldiv.sv =====
// Bit-serial unsigned multiplier and restoring divider sharing one shift register.
`timescale 1ns / 1ps
module tsia_muldiv (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  tsia_pkg::md_req_t       req_i,
  output logic                    done_o,
  output logic [tsia_pkg::PW-1:0] result_o
);
  import tsia_pkg::*;

  logic          busy_q, busy_d, done_q, done_d;
  md_op_e        op_q, op_d;
  logic [6:0]    cnt_q, cnt_d;
  logic [PW-1:0] data_q, data_d;
  logic [TW-1:0] opnd_q, opnd_d;
  logic [TW-1:0] rem_q, rem_d;
  logic [TW:0]   upper, rem_sh, rem_sub;
  logic          ge, last;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    op_d   = op_q;
    cnt_d  = cnt_q;
    data_d = data_q;
    opnd_d = opnd_q;
    rem_d  = rem_q;
    upper  = {1'b0, data_q[PW-1:TW]} + (data_q[0] ? {1'b0, opnd_q} : '0);
    rem_sh = {rem_q, data_q[PW-1]};
    rem_sub = rem_sh - {1'b0, opnd_q};
    ge     = rem_sh >= {1'b0, opnd_q};
    last   = (op_q == MD_MUL) ? (cnt_q == 7'd47) : (cnt_q == 7'd95);
    if (req_i.start) begin
      busy_d = 1'b1;
      op_d   = req_i.op;
      cnt_d  = '0;
      opnd_d = req_i.b;
      rem_d  = '0;
      data_d = (req_i.op == MD_MUL) ? {{TW{1'b0}}, req_i.a[TW-1:0]} : req_i.a;
    end else if (busy_q) begin
      if (op_q == MD_MUL) begin
        data_d = {upper, data_q[TW-1:1]};
      end else begin
        rem_d  = ge ? rem_sub[TW-1:0] : rem_sh[TW-1:0];
        data_d = {data_q[PW-2:0], ge};
      end
      cnt_d = cnt_q + 7'd1;
      if (last) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    cnt_q  <= cnt_d;
    data_q <= data_d;
    opnd_q <= opnd_d;
    rem_q  <= rem_d;
  end

  assign done_o   = done_q;
  assign result_o = data_q;

endmodule

// ===== rtl/time_series_interp_and_average.sv =====
// Top level: request sequencer for loads, point queries and interval averages.
`timescale 1ns / 1ps
// Usage: requests enter on the s_axis channel, one transaction per request, with the
// request code in tuser. Every request yields exactly one transaction on m_axis with
// the answer in tdata and the status code in tuser. Loads answer zero with status ok.
// The cfg channel writes the count of samples in use; it is always ready and must be
// written only while no request is in flight.
// Loads and rejected queries go straight to the answer. A point query takes a binary
// search over the samples in use, then, when it interpolates, a serial multiply and
// a serial divide that share one arithmetic unit. An interval average on a rate
// series walks the samples, runs a serial multiply for each piece that overlaps the
// interval, and ends with the serial divide unless no piece overlaps. One request
// is worked on at a time.
// Reset clears the sample count, the series kinds and the present flags; time and
// value memories are not cleared. A finished answer waits in the output register
// while the next request is already accepted; a stalled receiver holds the block only
// once the next answer is ready.
module time_series_interp_and_average #(
  parameter int unsigned MAX_SAMPLES = 1024,
  parameter int unsigned MAX_SERIES  = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // series_index, sample_index, time_a, time_b, value_in, kind_in
  input  logic [159:0] s_axis_tdata,
  // req_type
  input  logic [2:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // result_value
  output logic [47:0]  m_axis_tdata,
  // status
  output logic [1:0]   m_axis_tuser,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [10:0]  cfg_data_i
);
  import tsia_pkg::*;

  localparam int unsigned AW  = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int unsigned NW  = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned SW  = (MAX_SERIES > 1) ? $clog2(MAX_SERIES) : 1;
  localparam int unsigned VAW = SW + AW;

  logic [3:0]           in_series;
  logic [9:0]           in_slot;
  logic signed [TW-1:0] in_ta, in_tb, in_val;
  logic [1:0]           in_kind;
  logic [2:0]           in_req;
  logic [8:0]           s_ext;
  logic [16:0]          slot_ext;
  logic [SW-1:0]        s_idx;
  logic [AW-1:0]        slot_idx;
  logic                 s_ok, slot_ok, accept;

  assign in_series = s_axis_tdata[3:0];
  assign in_slot   = s_axis_tdata[13:4];
  assign in_ta     = s_axis_tdata[61:14];
  assign in_tb     = s_axis_tdata[109:62];
  assign in_val    = s_axis_tdata[157:110];
  assign in_kind   = s_axis_tdata[159:158];
  assign in_req    = s_axis_tuser;
  assign s_ext     = 9'(in_series);
  assign slot_ext  = 17'(in_slot);
  assign s_idx     = s_ext[SW-1:0];
  assign slot_idx  = slot_ext[AW-1:0];
  assign s_ok      = 32'(s_ext) < MAX_SERIES;
  assign slot_ok   = 32'(slot_ext) < MAX_SAMPLES;

  logic [10:0]   siu_q;
  logic [31:0]   cfg_ext;
  logic [NW-1:0] n_cur;

  assign cfg_ready_o = 1'b1;
  assign cfg_ext     = 32'(siu_q);
  assign n_cur       = (cfg_ext > MAX_SAMPLES) ? NW'(MAX_SAMPLES) : NW'(cfg_ext);

  logic [1:0] kind_arr_q [MAX_SERIES];
  logic       pres_arr_q [MAX_SERIES];

  state_e               state_q, state_d;
  logic [SW-1:0]        s_q, s_d;
  logic signed [TW-1:0] tq_q, tq_d, ta_q, ta_d, tb_q, tb_d;
  logic [1:0]           kind_q, kind_d;
  logic [NW-1:0]        n_q, n_d, lo_q, lo_d, hi_q, hi_d, k_q, k_d;
  logic [AW-1:0]        mid_q, mid_d;
  logic signed [TW-1:0] t0_q, t0_d, t1_q, t1_d, v0_q, v0_d, prev_q, prev_d;
  logic signed [PW:0]   acc_q, acc_d;
  logic [TW-1:0]        cov_q, cov_d, len_q, len_d;
  logic                 neg_q, neg_d, last_q, last_d;
  logic [TW-1:0]        res_q, res_d;
  logic [1:0]           stat_q, stat_d;

  logic                 out_valid_q, out_load;
  logic [TW-1:0]        out_data_q;
  logic [1:0]           out_stat_q;

  logic [AW-1:0]        t_raddr, v_ridx;
  logic [TW-1:0]        t_rdata, v_rdata;
  logic signed [TW-1:0] trd, vrd;
  md_req_t              md_req;
  logic                 md_done;
  logic [PW-1:0]        md_res;

  logic [NW:0]          mid_sum;
  logic signed [TW:0]   dv;
  logic signed [TW-1:0] pa, pb, dt;
  logic [TW-1:0]        vmag, q48;
  logic [PW:0]          padd;
  logic signed [PW:0]   amag;
  logic                 pt_ok, rate_ok;

  assign trd    = $signed(t_rdata);
  assign vrd    = $signed(v_rdata);
  assign accept = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    s_d = s_q; tq_d = tq_q; ta_d = ta_q; tb_d = tb_q; kind_d = kind_q;
    n_d = n_q; lo_d = lo_q; hi_d = hi_q; k_d = k_q; mid_d = mid_q;
    t0_d = t0_q; t1_d = t1_q; v0_d = v0_q; prev_d = prev_q;
    acc_d = acc_q; cov_d = cov_q; len_d = len_q; neg_d = neg_q; last_d = last_q;
    res_d = res_q; stat_d = stat_q;
    out_load = 1'b0;
    t_raddr = '0;
    v_ridx  = '0;
    md_req  = '{start: 1'b0, op: MD_MUL, a: '0, b: '0};
    mid_sum = ({1'b0, lo_q} + {1'b0, hi_q}) >> 1;
    dv      = {trd[TW-1], trd} - {v0_q[TW-1], v0_q};
    dv      = {vrd[TW-1], vrd} - {v0_q[TW-1], v0_q};
    pa      = '0;
    pb      = '0;
    dt      = t1_q - t0_q;
    vmag    = vrd[TW-1] ? TW'(-vrd) : TW'(vrd);
    q48     = md_res[TW-1:0];
    padd    = {1'b0, md_res};
    amag    = acc_q[PW] ? -acc_q : acc_q;
    pt_ok   = s_ok && pres_arr_q[s_idx] && (n_cur != '0);
    rate_ok = s_ok && pres_arr_q[s_idx] && (kind_arr_q[s_idx] == KIND_RATE) &&
              (in_tb > in_ta);
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          s_d = s_idx; ta_d = in_ta; tb_d = in_tb; tq_d = in_ta;
          kind_d = kind_arr_q[s_idx];
          n_d = n_cur; lo_d = '0; hi_d = n_cur; k_d = '0;
          acc_d = '0; cov_d = '0; last_d = 1'b0;
          res_d = '0; stat_d = STAT_OK;
          state_d = ST_RESP;
          case (in_req)
            REQ_POINT: begin
              if (pt_ok) state_d = ST_SRCH;
              else stat_d = STAT_ABSENT;
            end
            REQ_INTERVAL: begin
              if (rate_ok) begin
                if (n_cur != '0) state_d = ST_IRD;
                else stat_d = STAT_ABSENT;
              end else begin
                tq_d = in_tb;
                if (pt_ok) state_d = ST_SRCH;
                else stat_d = STAT_ABSENT;
              end
            end
            default: state_d = ST_RESP;
          endcase
        end
      end
      ST_SRCH: begin
        if (lo_q < hi_q) begin
          mid_d   = AW'(mid_sum);
          t_raddr = AW'(mid_sum);
          state_d = ST_SCMP;
        end else begin
          state_d = ST_PSEL;
        end
      end
      ST_SCMP: begin
        if (trd < tq_q) lo_d = NW'(mid_q) + NW'(1);
        else hi_d = NW'(mid_q);
        state_d = ST_SRCH;
      end
      ST_PSEL: begin
        if (lo_q == '0) begin
          v_ridx  = '0;
          state_d = ST_PHOLD;
        end else if (lo_q == n_q) begin
          v_ridx  = AW'(n_q - NW'(1));
          state_d = ST_PHOLD;
        end else begin
          t_raddr = AW'(lo_q - NW'(1));
          v_ridx  = AW'(lo_q - NW'(1));
          state_d = ST_PR1;
        end
      end
      ST_PHOLD: begin
        res_d   = v_rdata;
        state_d = ST_RESP;
      end
      ST_PR1: begin
        t0_d    = trd;
        v0_d    = vrd;
        t_raddr = AW'(lo_q);
        v_ridx  = AW'(lo_q);
        state_d = ST_PR2;
      end
      ST_PR2: begin
        t1_d = trd;
        if (kind_q != KIND_INTERP || !(trd > t0_q)) begin
          res_d   = v_rdata;
          state_d = ST_RESP;
        end else begin
          neg_d   = dv[TW];
          pa      = tq_q - t0_q;
          md_req  = '{start: 1'b1, op: MD_MUL, a: PW'(TW'(pa)),
                      b: dv[TW] ? TW'(-dv) : TW'(dv)};
          state_d = ST_PMUL;
        end
      end
      ST_PMUL: begin
        if (md_done) begin
          md_req  = '{start: 1'b1, op: MD_DIV, a: md_res, b: TW'(dt)};
          state_d = ST_PDIV;
        end
      end
      ST_PDIV: begin
        if (md_done) begin
          res_d   = TW'(v0_q) + (neg_q ? TW'(-q48) : q48);
          state_d = ST_RESP;
        end
      end
      ST_IRD: begin
        if (k_q == n_q || (k_q != '0 && prev_q >= tb_q)) begin
          state_d = ST_ILAST;
        end else begin
          t_raddr = AW'(k_q);
          v_ridx  = AW'(k_q);
          state_d = ST_ICHK;
        end
      end
      ST_ICHK: begin
        pa     = (k_q == '0 || prev_q < ta_q) ? ta_q : prev_q;
        pb     = (trd > tb_q) ? tb_q : trd;
        prev_d = trd;
        last_d = 1'b0;
        if (pb > pa) begin
          len_d   = TW'(pb - pa);
          neg_d   = vrd[TW-1];
          md_req  = '{start: 1'b1, op: MD_MUL, a: PW'(vmag), b: TW'(pb - pa)};
          state_d = ST_IMUL;
        end else begin
          k_d     = k_q + NW'(1);
          state_d = ST_IRD;
        end
      end
      ST_ILAST: begin
        t_raddr = AW'(n_q - NW'(1));
        v_ridx  = AW'(n_q - NW'(1));
        state_d = ST_ILCHK;
      end
      ST_ILCHK: begin
        pa = (trd < ta_q) ? ta_q : trd;
        pb = tb_q;
        if (pb > pa) begin
          len_d   = TW'(pb - pa);
          neg_d   = vrd[TW-1];
          last_d  = 1'b1;
          md_req  = '{start: 1'b1, op: MD_MUL, a: PW'(vmag), b: TW'(pb - pa)};
          state_d = ST_IMUL;
        end else begin
          state_d = ST_IDIV;
        end
      end
      ST_IMUL: begin
        if (md_done) begin
          acc_d = neg_q ? acc_q - $signed(padd) : acc_q + $signed(padd);
          cov_d = cov_q + len_q;
          if (last_q) begin
            state_d = ST_IDIV;
          end else begin
            k_d     = k_q + NW'(1);
            state_d = ST_IRD;
          end
        end
      end
      ST_IDIV: begin
        if (cov_q == '0) begin
          stat_d  = STAT_NOCOVER;
          res_d   = '0;
          state_d = ST_RESP;
        end else begin
          neg_d   = acc_q[PW];
          md_req  = '{start: 1'b1, op: MD_DIV, a: PW'(amag), b: cov_q};
          state_d = ST_IDWAIT;
        end
      end
      ST_IDWAIT: begin
        if (md_done) begin
          res_d   = neg_q ? TW'(-q48) : q48;
          state_d = ST_RESP;
        end
      end
      ST_RESP: begin
        if (!out_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      siu_q       <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < MAX_SERIES; i++) begin
        kind_arr_q[i] <= KIND_INTERP;
        pres_arr_q[i] <= 1'b0;
      end
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        siu_q <= cfg_data_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (accept && s_ok && in_req == REQ_LOAD_VAL && slot_ok) begin
        pres_arr_q[s_idx] <= 1'b1;
      end
      if (accept && s_ok && in_req == REQ_SET_KIND) begin
        pres_arr_q[s_idx] <= 1'b1;
        kind_arr_q[s_idx] <= in_kind;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    s_q <= s_d; tq_q <= tq_d; ta_q <= ta_d; tb_q <= tb_d; kind_q <= kind_d;
    n_q <= n_d; lo_q <= lo_d; hi_q <= hi_d; k_q <= k_d; mid_q <= mid_d;
    t0_q <= t0_d; t1_q <= t1_d; v0_q <= v0_d; prev_q <= prev_d;
    acc_q <= acc_d; cov_q <= cov_d; len_q <= len_d; neg_q <= neg_d; last_q <= last_d;
    res_q <= res_d; stat_q <= stat_d;
    if (out_load) begin
      out_data_q <= res_q;
      out_stat_q <= stat_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_stat_q;

  tsia_mem #(
    .AW    (AW),
    .VAW   (VAW),
    .TDEPTH(MAX_SAMPLES)
  ) u_mem (
    .clk_i    (clk_i),
    .t_we_i   (accept && in_req == REQ_LOAD_TIME && slot_ok),
    .t_waddr_i(slot_idx),
    .t_wdata_i(in_ta),
    .t_raddr_i(t_raddr),
    .t_rdata_o(t_rdata),
    .v_we_i   (accept && in_req == REQ_LOAD_VAL && slot_ok && s_ok),
    .v_waddr_i({s_idx, slot_idx}),
    .v_wdata_i(in_val),
    .v_raddr_i({s_q, v_ridx}),
    .v_rdata_o(v_rdata)
  );

  tsia_muldiv u_muldiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (md_req),
    .done_o  (md_done),
    .result_o(md_res)
  );

endmodule
